>>> hw/rtl/integer_literal_classifier_unit_assert.svh
// Assertion macros shared by the checker of the integer literal classifier.
`ifndef INTEGER_LITERAL_CLASSIFIER_UNIT_ASSERT_SVH
`define INTEGER_LITERAL_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ILC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define ILC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ILC_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ilc_pkg.sv
// Types, constants and transition functions of the integer literal classifier.
`timescale 1ns / 1ps
`default_nettype none

package ilc_pkg;

  // Request kinds.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  // Token classes.
  localparam logic [1:0] CLS_OCT = 2'd0;
  localparam logic [1:0] CLS_DEC = 2'd1;
  localparam logic [1:0] CLS_HEX = 2'd2;
  localparam logic [1:0] CLS_ERR = 2'd3;

  // DFA states.
  localparam int         ST_W       = 3;
  localparam logic [2:0] ST_INIT    = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_DEC     = 3'd2;
  localparam logic [2:0] ST_HEX_PFX = 3'd3;
  localparam logic [2:0] ST_HEX     = 3'd4;
  localparam logic [2:0] ST_OCT     = 3'd5;
  localparam logic [2:0] ST_SIGN    = 3'd6;
  localparam logic [2:0] ST_DEAD    = 3'd7;

  // Alphabet symbols: 0-9 digits, 10-15 A-F, 16-21 a-f, then x, X, +, -.
  localparam logic [4:0] SYM_A_UP   = 5'd10;
  localparam logic [4:0] SYM_A_LO   = 5'd16;
  localparam logic [4:0] SYM_X_LO   = 5'd22;
  localparam logic [4:0] SYM_X_UP   = 5'd23;
  localparam logic [4:0] SYM_PLUS   = 5'd24;
  localparam logic [4:0] SYM_MINUS  = 5'd25;
  localparam logic [4:0] SYM_NONE   = 5'd26;

  // Character codes.
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_A_UP   = 8'h41;
  localparam logic [7:0] CH_F_UP   = 8'h46;
  localparam logic [7:0] CH_A_LO   = 8'h61;
  localparam logic [7:0] CH_F_LO   = 8'h66;
  localparam logic [7:0] CH_X_LO   = 8'h78;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] DELIM_RST = 8'h23;

  localparam int         LEN_W   = 8;
  localparam logic [7:0] LEN_MAX = 8'hFF;
  localparam int         TOTAL_W = 16;

  // Token queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  // Configuration port.
  localparam int         CFG_ADDR_W        = 3;
  localparam int         CFG_DATA_W        = 32;
  localparam logic [0:0] REG_IDX_DELIMITER = 1'b0;

  typedef struct packed {
    logic [1:0]       cls;
    logic [LEN_W-1:0] len;
  } tok_t;

  function automatic logic [4:0] symbol_of(input logic [7:0] ch);
    logic [4:0] sym;
    sym = SYM_NONE;
    if (ch >= CH_0 && ch <= CH_9) begin
      sym = 5'(ch - CH_0);
    end else if (ch >= CH_A_UP && ch <= CH_F_UP) begin
      sym = SYM_A_UP + 5'(ch - CH_A_UP);
    end else if (ch >= CH_A_LO && ch <= CH_F_LO) begin
      sym = SYM_A_LO + 5'(ch - CH_A_LO);
    end else if (ch == CH_X_LO) begin
      sym = SYM_X_LO;
    end else if (ch == CH_X_UP) begin
      sym = SYM_X_UP;
    end else if (ch == CH_PLUS) begin
      sym = SYM_PLUS;
    end else if (ch == CH_MINUS) begin
      sym = SYM_MINUS;
    end
    return sym;
  endfunction

  // Transition function; sym is always an alphabet symbol here.
  function automatic logic [2:0] next_state(input logic [2:0] st, input logic [4:0] sym);
    logic       is_dig;
    logic       is_oct;
    logic       is_nz;
    logic       is_hex;
    logic       is_x;
    logic [2:0] nst;
    is_dig = (sym < SYM_A_UP);
    is_oct = (sym < 5'd8);
    is_nz  = is_dig && (sym != 5'd0);
    is_hex = (sym < SYM_X_LO);
    is_x   = (sym == SYM_X_LO) || (sym == SYM_X_UP);
    nst    = ST_DEAD;
    case (st)
      ST_INIT: begin
        if (sym == 5'd0) nst = ST_ZERO;
        else if (is_nz) nst = ST_DEC;
        else if (sym == SYM_PLUS || sym == SYM_MINUS) nst = ST_SIGN;
      end
      ST_ZERO: begin
        if (is_oct) nst = ST_OCT;
        else if (is_x) nst = ST_HEX_PFX;
      end
      ST_DEC: begin
        if (is_dig) nst = ST_DEC;
      end
      ST_HEX_PFX, ST_HEX: begin
        if (is_hex) nst = ST_HEX;
      end
      ST_OCT: begin
        if (is_oct) nst = ST_OCT;
      end
      ST_SIGN: begin
        if (is_nz) nst = ST_DEC;
      end
      default: begin
        nst = ST_DEAD;
      end
    endcase
    return nst;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/integer_literal_classifier_unit.sv
// Top level of the integer literal classifier: config port, front, queue and back.
`timescale 1ns / 1ps
`default_nettype none

// One character request per cycle while in_stall is low; the front's DFA step is combinational.
// A closing request's token is queued, then the back pops it into the result register.
// The four-entry token queue lets the front take requests under out_stall until it fills.
// Reset (synchronous, rst_n low) clears the token state, the class counts and the queue,
// and sets the delimiter to '#'; no clearing pass is needed.
module integer_literal_classifier_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Character requests.
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_kind,
  input  wire logic [7:0]                      in_char_code,
  // Token results.
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           out_token_class,
  output logic [7:0]                           out_token_length,
  output logic [15:0]                          out_decimal_total,
  output logic [15:0]                          out_octal_total,
  output logic [15:0]                          out_hex_total,
  // Configuration port.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ilc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [ilc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ilc_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);
  import ilc_pkg::*;

  logic [7:0]   delim_r, delim_nxt;
  logic [0:0]   reg_idx;
  logic         cfg_wr;
  logic         q_full;
  logic         q_empty;
  logic         q_push;
  logic         q_pop;
  tok_t         push_tok;
  tok_t         head_tok;

  // The register index is the word address; byte offset bits are ignored.
  // Writes to an index without a register are dropped and read back as zero.
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    delim_nxt = delim_r;
    if (cfg_wr && reg_idx == REG_IDX_DELIMITER) delim_nxt = pwdata[7:0];
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_IDX_DELIMITER) prdata = {{(CFG_DATA_W-8){1'b0}}, delim_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIM_RST;
    end else begin
      delim_r <= delim_nxt;
    end
  end

  // The front checks each request against the delimiter first, so a delimiter
  // that is also a literal character always ends the token. Only tokens with
  // at least one character are pushed into the queue.
  ilc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_char_code (in_char_code),
    .delimiter    (delim_r),
    .q_full       (q_full),
    .push         (q_push),
    .push_tok     (push_tok)
  );

  ilc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_tok)
  );

  // The back counts each class as its token leaves the queue, so the totals in
  // a result always include that token.
  ilc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (head_tok),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_token_class   (out_token_class),
    .out_token_length  (out_token_length),
    .out_decimal_total (out_decimal_total),
    .out_octal_total   (out_octal_total),
    .out_hex_total     (out_hex_total)
  );

endmodule

`default_nettype wire

>>> hw/rtl/ilc_front.sv
// Front part: accepts character requests, runs the DFA and emits finished tokens.
`timescale 1ns / 1ps
`default_nettype none

module ilc_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic         in_kind,
  input  wire logic [7:0]   in_char_code,
  input  wire logic [7:0]   delimiter,
  input  wire logic         q_full,
  output logic              push,
  output ilc_pkg::tok_t     push_tok
);
  import ilc_pkg::*;

  logic [ST_W-1:0]  state_r, state_nxt;
  logic             bad_r, bad_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             accept;
  logic             finish;
  logic [4:0]       sym;
  logic [1:0]       cls;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign finish   = (in_kind == KIND_EOS) || (in_char_code == delimiter);
  assign sym      = symbol_of(in_char_code);

  always_comb begin
    if (bad_r) begin
      cls = CLS_ERR;
    end else begin
      case (state_r)
        ST_ZERO, ST_OCT: cls = CLS_OCT;
        ST_DEC:          cls = CLS_DEC;
        ST_HEX:          cls = CLS_HEX;
        default:         cls = CLS_ERR;
      endcase
    end
  end

  assign push         = accept && finish && (len_r != '0);
  assign push_tok.cls = cls;
  assign push_tok.len = len_r;

  always_comb begin
    state_nxt = state_r;
    bad_nxt   = bad_r;
    len_nxt   = len_r;
    if (accept) begin
      if (finish) begin
        state_nxt = ST_INIT;
        bad_nxt   = 1'b0;
        len_nxt   = '0;
      end else begin
        if (len_r != LEN_MAX) len_nxt = len_r + 1'b1;
        if (sym == SYM_NONE) begin
          bad_nxt   = 1'b1;
          state_nxt = ST_DEAD;
        end else if (!bad_r) begin
          state_nxt = next_state(state_r, sym);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      bad_r   <= 1'b0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bad_r   <= bad_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ilc_queue.sv
// Short token queue that decouples the front from the back.
`timescale 1ns / 1ps
`default_nettype none

module ilc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ilc_pkg::tok_t push_tok,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output ilc_pkg::tok_t      head
);
  import ilc_pkg::*;

  tok_t                slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_r, wr_nxt;
  logic [QUEUE_AW-1:0] rd_r, rd_nxt;
  logic [QUEUE_CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ilc_back.sv
// Back part: updates the class counts and holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module ilc_back #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire ilc_pkg::tok_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_token_class,
  output logic [7:0]         out_token_length,
  output logic [15:0]        out_decimal_total,
  output logic [15:0]        out_octal_total,
  output logic [15:0]        out_hex_total
);
  import ilc_pkg::*;

  logic                   valid_r, valid_nxt;
  tok_t                   tok_r;
  logic [COUNT_WIDTH-1:0] dec_r, dec_nxt;
  logic [COUNT_WIDTH-1:0] oct_r, oct_nxt;
  logic [COUNT_WIDTH-1:0] hex_r, hex_nxt;

  assign q_pop = !q_empty && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    dec_nxt   = dec_r;
    oct_nxt   = oct_r;
    hex_nxt   = hex_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
      case (q_head.cls)
        CLS_OCT: if (oct_r != '1) oct_nxt = oct_r + 1'b1;
        CLS_DEC: if (dec_r != '1) dec_nxt = dec_r + 1'b1;
        CLS_HEX: if (hex_r != '1) hex_nxt = hex_r + 1'b1;
        default: ;
      endcase
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) tok_r <= q_head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dec_r   <= '0;
      oct_r   <= '0;
      hex_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      dec_r   <= dec_nxt;
      oct_r   <= oct_nxt;
      hex_r   <= hex_nxt;
    end
  end

  // The counts only move on a pop, which also loads the result, so the
  // reported totals can be taken straight from the counters.
  generate
    if (COUNT_WIDTH >= TOTAL_W) begin : g_trunc
      assign out_decimal_total = dec_r[TOTAL_W-1:0];
      assign out_octal_total   = oct_r[TOTAL_W-1:0];
      assign out_hex_total     = hex_r[TOTAL_W-1:0];
    end else begin : g_ext
      assign out_decimal_total = {{(TOTAL_W-COUNT_WIDTH){1'b0}}, dec_r};
      assign out_octal_total   = {{(TOTAL_W-COUNT_WIDTH){1'b0}}, oct_r};
      assign out_hex_total     = {{(TOTAL_W-COUNT_WIDTH){1'b0}}, hex_r};
    end
  endgenerate

  assign out_valid        = valid_r;
  assign out_token_class  = tok_r.cls;
  assign out_token_length = tok_r.len;

endmodule

`default_nettype wire

>>> hw/rtl/ilc_checker.sv
// Port-level checker of the integer literal classifier and its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "integer_literal_classifier_unit_assert.svh"

module ilc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_token_class,
  input wire logic [7:0]  out_token_length,
  input wire logic [15:0] out_decimal_total,
  input wire logic [15:0] out_octal_total,
  input wire logic [15:0] out_hex_total
);

  logic [47:0] tot_bits;
  logic [57:0] res_bits;

  assign tot_bits = {out_decimal_total, out_octal_total, out_hex_total};
  assign res_bits = {out_token_class, out_token_length, tot_bits};

  // Every reported token has at least one character.
  `ILC_ASSERT_IMP(a_len_nonzero, out_valid, out_token_length != 8'd0, "empty token reported")

  // A stalled result keeps its class, length and totals.
  `ILC_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(res_bits), "result moved")

  // The totals only move together with a new result.
  `ILC_ASSERT_NXT(a_totals_with_result, 1'b1, out_valid || $stable(tot_bits), "totals moved")

  // Reset empties the result register.
  `ILC_ASSERT_RST(a_reset_clears, !rst_n, !out_valid, "result valid after reset")

endmodule

bind integer_literal_classifier_unit ilc_checker u_ilc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_token_class   (out_token_class),
  .out_token_length  (out_token_length),
  .out_decimal_total (out_decimal_total),
  .out_octal_total   (out_octal_total),
  .out_hex_total     (out_hex_total)
);

`default_nettype wire

>>> dv/integer_literal_classifier_unit_checker.sv
// Passive checker: predicts literal classifier results from observed requests and compares them.
`timescale 1ns / 1ps

module integer_literal_classifier_unit_checker #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_kind,
  input  logic [7:0]                          in_char_code,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [1:0]                          out_token_class,
  input  logic [7:0]                          out_token_length,
  input  logic [15:0]                         out_decimal_total,
  input  logic [15:0]                         out_octal_total,
  input  logic [15:0]                         out_hex_total,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ilc_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [ilc_pkg::CFG_DATA_W-1:0]      pwdata,
  input  logic                                pready,
  output int                                  fail_count,
  output int                                  awaiting
);
  import ilc_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] DELIM_ADDR = {REG_IDX_DELIMITER, 2'b00};
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [1:0]         cls;
    logic [LEN_W-1:0]   len;
    logic [TOTAL_W-1:0] dec_total;
    logic [TOTAL_W-1:0] oct_total;
    logic [TOTAL_W-1:0] hex_total;
  } token_result_t;

  token_result_t          awaited_tokens[$];
  logic [7:0]             delimiter;
  logic [2:0]             lex_state;
  logic                   bad_seen;
  logic [LEN_W-1:0]       tok_len;
  logic [COUNT_WIDTH-1:0] dec_count;
  logic [COUNT_WIDTH-1:0] oct_count;
  logic [COUNT_WIDTH-1:0] hex_count;
  int                     failures = 0;

  initial begin
    fail_count = 0;
    awaiting   = 0;
  end

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_0) && (ch <= CH_9);
  endfunction

  function automatic logic is_hex_digit(input logic [7:0] ch);
    return is_digit(ch) || (ch >= CH_A_UP && ch <= CH_F_UP) || (ch >= CH_A_LO && ch <= CH_F_LO);
  endfunction

  function automatic logic is_alphabet(input logic [7:0] ch);
    return is_hex_digit(ch) || ch == CH_X_LO || ch == CH_X_UP || ch == CH_PLUS || ch == CH_MINUS;
  endfunction

  // One lexer step for a character that is known to be in the alphabet.
  function automatic logic [2:0] dfa_step(input logic [2:0] st, input logic [7:0] ch);
    logic       octal;
    logic       xmark;
    logic [2:0] nxt;
    octal = (ch >= CH_0) && (ch <= CH_0 + 8'd7);
    xmark = (ch == CH_X_LO) || (ch == CH_X_UP);
    nxt   = ST_DEAD;
    case (st)
      ST_INIT: begin
        if (ch == CH_0) nxt = ST_ZERO;
        else if (is_digit(ch)) nxt = ST_DEC;
        else if (ch == CH_PLUS || ch == CH_MINUS) nxt = ST_SIGN;
      end
      ST_ZERO: begin
        if (octal) nxt = ST_OCT;
        else if (xmark) nxt = ST_HEX_PFX;
      end
      ST_DEC: begin
        if (is_digit(ch)) nxt = ST_DEC;
      end
      ST_HEX_PFX, ST_HEX: begin
        if (is_hex_digit(ch)) nxt = ST_HEX;
      end
      ST_OCT: begin
        if (octal) nxt = ST_OCT;
      end
      ST_SIGN: begin
        if (is_digit(ch) && ch != CH_0) nxt = ST_DEC;
      end
      default: begin
        nxt = ST_DEAD;
      end
    endcase
    return nxt;
  endfunction

  // A delimiter or end of string closes the pending token; an empty one yields nothing.
  task automatic close_token();
    token_result_t res;
    if (tok_len != 0) begin
      res.cls = CLS_ERR;
      if (!bad_seen) begin
        case (lex_state)
          ST_ZERO, ST_OCT: begin
            res.cls = CLS_OCT;
            if (oct_count != '1) oct_count++;
          end
          ST_DEC: begin
            res.cls = CLS_DEC;
            if (dec_count != '1) dec_count++;
          end
          ST_HEX: begin
            res.cls = CLS_HEX;
            if (hex_count != '1) hex_count++;
          end
          default: begin
            res.cls = CLS_ERR;
          end
        endcase
      end
      res.len       = tok_len;
      res.dec_total = TOTAL_W'(dec_count);
      res.oct_total = TOTAL_W'(oct_count);
      res.hex_total = TOTAL_W'(hex_count);
      awaited_tokens.push_back(res);
    end
    lex_state = ST_INIT;
    bad_seen  = 1'b0;
    tok_len   = '0;
  endtask

  task automatic classify_request(input logic kind, input logic [7:0] ch);
    if (kind == KIND_EOS || ch == delimiter) begin
      close_token();
    end else begin
      if (tok_len != LEN_MAX) tok_len++;
      if (!is_alphabet(ch)) begin
        bad_seen  = 1'b1;
        lex_state = ST_DEAD;
      end else if (!bad_seen) begin
        lex_state = dfa_step(lex_state, ch);
      end
    end
  endtask

  task automatic check_result();
    token_result_t got;
    token_result_t want;
    got.cls       = out_token_class;
    got.len       = out_token_length;
    got.dec_total = out_decimal_total;
    got.oct_total = out_octal_total;
    got.hex_total = out_hex_total;
    if (awaited_tokens.size() == 0) begin
      if (failures < REPORT_LIMIT) begin
        $display("%0t: unexpected result: class %0d len %0d totals dec %0d oct %0d hex %0d",
                 $time, got.cls, got.len, got.dec_total, got.oct_total, got.hex_total);
      end
      failures++;
    end else begin
      want = awaited_tokens.pop_front();
      if (got.cls !== want.cls || got.len !== want.len || got.dec_total !== want.dec_total ||
          got.oct_total !== want.oct_total || got.hex_total !== want.hex_total) begin
        if (failures < REPORT_LIMIT) begin
          $display("%0t: result mismatch, expected / actual:", $time);
          $display("  class %0d / %0d, length %0d / %0d", want.cls, got.cls, want.len, got.len);
          $display("  decimal %0d / %0d, octal %0d / %0d, hex %0d / %0d",
                   want.dec_total, got.dec_total, want.oct_total, got.oct_total,
                   want.hex_total, got.hex_total);
        end
        failures++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      delimiter = DELIM_RST;
      lex_state = ST_INIT;
      bad_seen  = 1'b0;
      tok_len   = '0;
      dec_count = '0;
      oct_count = '0;
      hex_count = '0;
      awaited_tokens.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == DELIM_ADDR) begin
        delimiter = pwdata[7:0];
      end
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) classify_request(in_kind, in_char_code);
    end
    fail_count <= failures;
    awaiting   <= awaited_tokens.size();
  end

endmodule

>>> dv/integer_literal_classifier_unit_tb.sv
// Testbench top for the integer literal classifier: stimulus, pacing, watchdog and verdict.
`timescale 1ns / 1ps

module integer_literal_classifier_unit_tb;
  import ilc_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_ITEMS = 385;
  localparam int END_SETTLE  = 10;

  localparam logic [CFG_ADDR_W-1:0] DELIM_ADDR  = {REG_IDX_DELIMITER, 2'b00};
  // No register lives here, so a write to it must leave the delimiter alone.
  localparam logic [CFG_ADDR_W-1:0] UNUSED_ADDR = {~REG_IDX_DELIMITER, 2'b00};

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_kind      = KIND_CHAR;
  logic [7:0]            in_char_code = 8'h00;
  logic                  out_stall    = 1'b0;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr        = '0;
  logic [CFG_DATA_W-1:0] pwdata       = '0;

  logic                  in_stall;
  logic                  out_valid;
  logic [1:0]            out_token_class;
  logic [7:0]            out_token_length;
  logic [15:0]           out_decimal_total;
  logic [15:0]           out_octal_total;
  logic [15:0]           out_hex_total;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int         fail_count;
  int         awaiting;
  int         items_sent  = 0;
  int         idle_cycles = 0;
  int         out_hold    = 0;
  bit         in_burst    = 1'b0;
  bit         out_burst   = 1'b0;
  logic [7:0] delim_now   = DELIM_RST;

  initial begin
    forever #1 clk = ~clk;
  end

  integer_literal_classifier_unit #(.COUNT_WIDTH(16)) uut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_kind, .in_char_code,
    .out_valid, .out_stall, .out_token_class, .out_token_length,
    .out_decimal_total, .out_octal_total, .out_hex_total,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  integer_literal_classifier_unit_checker #(.COUNT_WIDTH(16)) token_check (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_kind, .in_char_code,
    .out_valid, .out_stall, .out_token_class, .out_token_length,
    .out_decimal_total, .out_octal_total, .out_hex_total,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .awaiting
  );

  // The result side draws a random stall length after each accepted result. Now and
  // then it flips into a burst mode where it never stalls, so back-to-back results and
  // a full token queue both get exercised.
  always @(posedge clk) begin : out_pacing
    int nxt;
    if (out_valid && !out_stall) begin
      if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
      nxt = out_burst ? 0 : $urandom_range(0, 10);
    end else begin
      nxt = (out_hold > 0) ? out_hold - 1 : 0;
    end
    out_hold = nxt;
    out_stall <= (nxt != 0);
  end

  // Any accepted request, result or register access counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("[integer_literal_classifier_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one request after a random gap and returns at the edge that accepts it.
  // With a zero gap, valid simply stays high into the next request.
  task automatic send_request(input logic kind, input logic [7:0] code);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_char_code <= code;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(KIND_CHAR, s[i]);
  endtask

  // End of string carries a random byte, which the block must ignore.
  task automatic end_string();
    send_request(KIND_EOS, 8'($urandom));
  endtask

  // Holds the sender off until every predicted result has come out. The checker's count
  // is registered, so the task waits on the clock before it trusts the count.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (4) @(posedge clk);
  endtask

  // Setup phase, then access phase; the write lands at the edge where pready is seen.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Upper data bits are random; only the low byte is the delimiter.
  task automatic set_delimiter(input logic [7:0] d);
    write_reg(DELIM_ADDR, {24'($urandom), d});
    delim_now = d;
  endtask

  function automatic logic [7:0] dec_digit();
    return CH_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] hex_digit();
    case ($urandom_range(0, 2))
      0: return dec_digit();
      1: return CH_A_UP + 8'($urandom_range(0, 5));
      default: return CH_A_LO + 8'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] alphabet_char();
    case ($urandom_range(0, 3))
      0: return hex_digit();
      1: return $urandom_range(0, 1) ? CH_X_UP : CH_X_LO;
      2: return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
      default: return dec_digit();
    endcase
  endfunction

  // Most tokens are well-formed literals with random digits; the rest are random alphabet
  // strings, tokens carrying an arbitrary byte, and empty tokens. Each ends with the
  // current delimiter or with end of string.
  task automatic send_token();
    logic [7:0] text[$];
    int         r;
    int         n;
    r = $urandom_range(0, 99);
    n = $urandom_range(0, 5);
    if (r < 22) begin
      text.push_back(CH_0);
      repeat (n) text.push_back(CH_0 + 8'($urandom_range(0, 7)));
    end else if (r < 46) begin
      case ($urandom_range(0, 2))
        0: text.push_back(CH_PLUS);
        1: text.push_back(CH_MINUS);
        default: ;
      endcase
      text.push_back(CH_0 + 8'($urandom_range(1, 9)));
      repeat (n) text.push_back(dec_digit());
    end else if (r < 70) begin
      // A bare prefix with no digits is a lexical error.
      text.push_back(CH_0);
      text.push_back($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
      repeat (n) text.push_back(hex_digit());
    end else if (r < 84) begin
      repeat (n + 1) text.push_back(alphabet_char());
    end else if (r < 95) begin
      repeat (n) text.push_back(alphabet_char());
      text.insert($urandom_range(0, n), 8'($urandom));
    end
    foreach (text[i]) send_request(KIND_CHAR, text[i]);
    if ($urandom_range(0, 4) == 0) end_string();
    else send_request(KIND_CHAR, delim_now);
  endtask

  logic [7:0] phase_delims[5];
  int         target;
  int         long_len;

  initial begin
    // Default hash, a comma, both byte extremes, and a delimiter inside the alphabet.
    phase_delims = '{DELIM_RST, 8'h2C, 8'h00, 8'hFF, CH_A_LO};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(UNUSED_ADDR, {24'($urandom), 8'h2C});
    set_delimiter(DELIM_RST);

    // Directed requests under the default delimiter: a bare zero, octal, signed decimal,
    // a sign followed by zero, hex in mixed case, a hex prefix alone, a bad character
    // closed by end of string, empty tokens at a delimiter and at end of string, and
    // the byte extremes as characters outside the alphabet.
    send_text("0#");
    send_text("017#");
    send_text("+9#");
    send_text("-0#");
    send_text("0xaF#");
    send_text("0X#");
    send_text("12g");
    end_string();
    send_text("#");
    end_string();
    send_request(KIND_CHAR, 8'h00);
    end_string();
    send_request(KIND_CHAR, 8'hFF);
    send_text("#");
    settle();

    foreach (phase_delims[p]) begin
      set_delimiter(phase_delims[p]);
      target = items_sent + PHASE_ITEMS;
      if (p == 0) begin
        // One long decimal literal, which saturates the length field when it reaches 255 characters.
        long_len = $urandom_range(250, 300);
        send_request(KIND_CHAR, CH_0 + 8'd1);
        repeat (long_len - 1) send_request(KIND_CHAR, dec_digit());
        send_request(KIND_CHAR, delim_now);
      end
      while (items_sent < target) begin
        in_burst = ($urandom_range(0, 5) == 0);
        send_token();
        if ($urandom_range(0, 59) == 0) settle();
      end
      settle();
    end

    repeat (END_SETTLE) @(posedge clk);
    if (fail_count == 0 && awaiting == 0) begin
      $display("[integer_literal_classifier_unit] OK");
    end else begin
      $display("[integer_literal_classifier_unit] ERROR");
    end
    $finish;
  end

endmodule
